FILE: src/rsd_pkg.sv
// ---------------------------------------------------------------------------
// rsd_pkg: shared types and functions of the record sorter
// Record layout, cell control bundle, state codes and the sort compare.
// ---------------------------------------------------------------------------
package rsd_pkg;

  localparam int RSD_CAPACITY = 64;

  typedef struct packed {
    logic [15:0] distance;
    logic [31:0] population;
    logic [15:0] handle;
  } record_t;

  // control bundle broadcast from the sequencer to every cell
  typedef struct packed {
    logic load;   // insert the broadcast record this cycle
    logic drain;  // shift the chain one place toward cell 0
  } cell_cmd_t;

  typedef enum logic [1:0] {
    ST_LOAD  = 2'b01,
    ST_DRAIN = 2'b10
  } rsd_state_t;

  // true if record a is ordered ahead of stored record b; on a full tie the
  // newer record goes ahead
  function automatic logic goes_before(record_t a, record_t b);
    logic res;
    if (a.distance != b.distance) begin
      res = (a.distance < b.distance);
    end else begin
      res = (a.population >= b.population);
    end
    return res;
  endfunction

endpackage

FILE: src/rsd_in_if.sv
// ---------------------------------------------------------------------------
// rsd_in_if: record input channel
// Valid/ready channel carrying one unsorted record and its end-of-set mark.
// ---------------------------------------------------------------------------
interface rsd_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] distance;
  logic [31:0] population;
  logic [15:0] handle;
  logic        final_record;

  modport source (output valid, distance, population, handle, final_record,
                  input ready);
  modport sink   (input valid, distance, population, handle, final_record,
                  output ready);
endinterface

FILE: src/rsd_out_if.sv
// ---------------------------------------------------------------------------
// rsd_out_if: sorted record output channel
// Valid/ready channel carrying one sorted record with set flags.
// ---------------------------------------------------------------------------
interface rsd_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] sorted_distance;
  logic [31:0] sorted_population;
  logic [15:0] sorted_handle;
  logic        run_end;
  logic        overflow;

  modport source (output valid, sorted_distance, sorted_population, sorted_handle,
                  run_end, overflow, input ready);
  modport sink   (input valid, sorted_distance, sorted_population, sorted_handle,
                  run_end, overflow, output ready);
endinterface

FILE: src/rsd_cell.sv
// ---------------------------------------------------------------------------
// rsd_cell: one slot of the insertion chain
// Holds one record. On load it keeps its record, takes the new record, or
// takes its left neighbor's; on drain it takes its right neighbor's.
// ---------------------------------------------------------------------------
module rsd_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  rsd_pkg::cell_cmd_t cmd,
  input  rsd_pkg::record_t new_rec,
  input  rsd_pkg::record_t prev_rec,
  input  logic             prev_vld,
  input  logic             prev_ins,
  input  rsd_pkg::record_t next_rec,
  input  logic             next_vld,
  output rsd_pkg::record_t rec_r,
  output logic             vld_r,
  output logic             ins
);
  import rsd_pkg::*;

  record_t rec_nxt;
  logic    vld_nxt;

  // an empty slot counts as a place the new record may go
  assign ins = !vld_r || goes_before(new_rec, rec_r);

  always_comb begin
    rec_nxt = rec_r;
    vld_nxt = vld_r;
    if (cmd.drain) begin
      rec_nxt = next_rec;
      vld_nxt = next_vld;
    end else if (cmd.load) begin
      if (prev_ins) begin
        rec_nxt = prev_rec;
        vld_nxt = prev_vld;
      end else if (ins) begin
        rec_nxt = new_rec;
        vld_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

endmodule

FILE: src/record_sorter_dist_asc_pop_desc.sv
// ---------------------------------------------------------------------------
// record_sorter_dist_asc_pop_desc: two-key insertion sorter
// Timing: a record enters the cell chain on acceptance; results of a set of N
//   records start the cycle after the final record, 1 per cycle when out ready.
// Throughput: 1 record per cycle while loading; the input stalls for the
//   N output transactions of a set, set by the single shifting cell chain.
// Reset: synchronous, clears cell valid bits, record count, overflow flag.
// ---------------------------------------------------------------------------
module record_sorter_dist_asc_pop_desc #(
  parameter int CAPACITY = rsd_pkg::RSD_CAPACITY
) (
  input  logic          clk,
  input  logic          rst_n,
  rsd_in_if.sink        in_rec,
  rsd_out_if.source     out_rec
);
  import rsd_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  rsd_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             dropped_r, dropped_nxt;

  record_t          new_rec;
  cell_cmd_t        cmd;
  logic             in_fire, out_fire, has_room;

  record_t          cell_rec [CAPACITY];
  logic [CAPACITY-1:0] cell_vld;
  logic [CAPACITY-1:0] cell_ins;

  assign new_rec.distance   = in_rec.distance;
  assign new_rec.population = in_rec.population;
  assign new_rec.handle     = in_rec.handle;

  assign in_rec.ready = (state_r == ST_LOAD);
  assign in_fire      = in_rec.valid && in_rec.ready;
  assign out_fire     = out_rec.valid && out_rec.ready;
  assign has_room     = (count_r < CNT_W'(CAPACITY));

  assign cmd.load  = in_fire && has_room;
  assign cmd.drain = out_fire;

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      record_t prev_rec_w, next_rec_w;
      logic    prev_vld_w, prev_ins_w, next_vld_w;

      if (i == 0) begin : g_head
        assign prev_rec_w = new_rec;
        assign prev_vld_w = 1'b0;
        assign prev_ins_w = 1'b0;
      end else begin : g_mid
        assign prev_rec_w = cell_rec[i-1];
        assign prev_vld_w = cell_vld[i-1];
        assign prev_ins_w = cell_ins[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
        assign next_rec_w = new_rec;
        assign next_vld_w = 1'b0;
      end else begin : g_body
        assign next_rec_w = cell_rec[i+1];
        assign next_vld_w = cell_vld[i+1];
      end

      rsd_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .new_rec  (new_rec),
        .prev_rec (prev_rec_w),
        .prev_vld (prev_vld_w),
        .prev_ins (prev_ins_w),
        .next_rec (next_rec_w),
        .next_vld (next_vld_w),
        .rec_r    (cell_rec[i]),
        .vld_r    (cell_vld[i]),
        .ins      (cell_ins[i])
      );
    end
  endgenerate

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    dropped_nxt = dropped_r;
    case (state_r)
      ST_LOAD: begin
        if (in_fire) begin
          if (has_room) begin
            count_nxt = count_r + CNT_W'(1);
          end else begin
            dropped_nxt = 1'b1;
          end
          if (in_rec.final_record) begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (out_fire) begin
          count_nxt = count_r - CNT_W'(1);
          // last transaction of the set: rearm for the next one
          if (count_r == CNT_W'(1)) begin
            state_nxt   = ST_LOAD;
            dropped_nxt = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_LOAD;
      count_r   <= '0;
      dropped_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      dropped_r <= dropped_nxt;
    end
  end

  assign out_rec.valid             = (state_r == ST_DRAIN);
  assign out_rec.sorted_distance   = cell_rec[0].distance;
  assign out_rec.sorted_population = cell_rec[0].population;
  assign out_rec.sorted_handle     = cell_rec[0].handle;
  assign out_rec.run_end           = (count_r == CNT_W'(1));
  assign out_rec.overflow          = dropped_r;

  // occupied cells always match the record count
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_vld) == int'(count_r))
    else $error("cell valid bits disagree with record count");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("record count beyond capacity");

  a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_rec.valid |-> cell_vld[0])
    else $error("output offered from an empty head cell");

  a_set_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && out_rec.run_end) |=> (count_r == '0 && !dropped_r && in_rec.ready))
    else $error("block not rearmed after last transaction of a set");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_rec.ready && out_rec.valid))
    else $error("loading and draining at once");

endmodule
